FILE: src/sxfb_pkg.sv
// Package with the shared constants and types of the sprite XOR framebuffer.
package sxfb_pkg;

  // Default screen geometry.
  localparam int ScreenWidthDefault  = 64;
  localparam int ScreenHeightDefault = 32;

  // Pixels packed into one framebuffer byte.
  localparam int PixPerByte = 8;

  // Width of the position values handled by the wrap unit.
  localparam int PosW = 8;

  // Action codes of an input transaction.
  typedef enum logic [1:0] {
    ACT_DRAW    = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_READ    = 2'd2,
    ACT_PRESENT = 2'd3
  } action_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_XMOD,
    ST_YMOD,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ,
    ST_CLEAR,
    ST_DONE
  } state_e;

endpackage

FILE: src/sxfb_wrap_sub.sv
// Shared compare-and-subtract unit that wraps a position against a limit.
module sxfb_wrap_sub (
  input  logic [sxfb_pkg::PosW-1:0] a_i,
  input  logic [sxfb_pkg::PosW-1:0] b_i,
  output logic                      ge_o,
  output logic [sxfb_pkg::PosW-1:0] res_o
);

  // Subtract the limit when the value reaches it, otherwise pass it on.
  always_comb begin
    ge_o  = (a_i >= b_i);
    res_o = ge_o ? (a_i - b_i) : a_i;
  end

endmodule

FILE: src/sprite_xor_framebuffer_top.sv
// Sprite XOR framebuffer: packed 1-bit pixel store driven by a small sequencer.
// Draw wraps x and y by repeated subtraction on one shared unit, then does 8 pixel
// read-modify-writes. One transaction is in work at a time, and the next can be taken
// in the cycle after the result is loaded.
// After reset the store is swept to zero with input held off.
module sprite_xor_framebuffer_top #(
  parameter int ScreenWidth  = sxfb_pkg::ScreenWidthDefault,
  parameter int ScreenHeight = sxfb_pkg::ScreenHeightDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic [7:0] sprite_byte_i,
  input  logic [7:0] read_address_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       collision_o,
  output logic [7:0] read_byte_o,
  output logic       was_modified_o
);

  localparam int RowBytes   = (ScreenWidth + sxfb_pkg::PixPerByte - 1) / sxfb_pkg::PixPerByte;
  localparam int StoreBytes = RowBytes * ScreenHeight;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int PosW       = sxfb_pkg::PosW;

  localparam logic [AddrW-1:0] LastAddr  = AddrW'(StoreBytes - 1);
  localparam logic [PosW-1:0]  WidthLim  = PosW'(ScreenWidth);
  localparam logic [PosW-1:0]  HeightLim = PosW'(ScreenHeight);

  sxfb_pkg::state_e state_q, state_d;

  // Transaction registers.
  sxfb_pkg::action_e action_q;
  logic [PosW-1:0]   x_q;
  logic [PosW-1:0]   y_q;
  logic [7:0]        spr_q;
  logic [7:0]        addr_q;
  logic              read_ok_q;
  logic              was_q;
  logic              hit_q;
  logic [2:0]        cnt_q;
  logic [AddrW-1:0]  row_q;
  logic [AddrW-1:0]  clr_q;
  logic              dirty_q;

  // Memory and its read data.
  logic [7:0]        mem_q [StoreBytes];
  logic [7:0]        rdata_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;

  // Output register.
  logic       out_valid_q;
  logic       coll_q;
  logic [7:0] rbyte_q;
  logic       wasmod_q;

  // Shared wrap unit.
  logic [PosW-1:0] unit_a;
  logic [PosW-1:0] unit_b;
  logic            unit_ge;
  logic [PosW-1:0] unit_res;

  logic             in_fire;
  logic             slot_free;
  logic             clr_last;
  logic             pix_bit;
  logic [7:0]       pix_mask;
  logic [AddrW-1:0] pix_addr;

  sxfb_wrap_sub u_wrap (
    .a_i  (unit_a),
    .b_i  (unit_b),
    .ge_o (unit_ge),
    .res_o(unit_res)
  );

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign clr_last  = (clr_q == LastAddr);
  assign pix_bit   = spr_q[3'd7 - cnt_q];
  assign pix_mask  = pix_bit ? (8'h80 >> x_q[2:0]) : 8'h00;
  assign pix_addr  = row_q + AddrW'(x_q[PosW-1:3]);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sxfb_pkg::ST_INIT: begin
        if (clr_last) state_d = sxfb_pkg::ST_IDLE;
      end
      sxfb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (sxfb_pkg::action_e'(action_i))
            sxfb_pkg::ACT_DRAW:  state_d = sxfb_pkg::ST_XMOD;
            sxfb_pkg::ACT_CLEAR: state_d = sxfb_pkg::ST_CLEAR;
            sxfb_pkg::ACT_READ:  state_d = sxfb_pkg::ST_READ;
            default:             state_d = sxfb_pkg::ST_DONE;
          endcase
        end
      end
      sxfb_pkg::ST_XMOD: begin
        if (!unit_ge) state_d = sxfb_pkg::ST_YMOD;
      end
      sxfb_pkg::ST_YMOD: begin
        if (!unit_ge) state_d = sxfb_pkg::ST_PIX_RD;
      end
      sxfb_pkg::ST_PIX_RD: state_d = sxfb_pkg::ST_PIX_WR;
      sxfb_pkg::ST_PIX_WR: begin
        state_d = (cnt_q == 3'd7) ? sxfb_pkg::ST_DONE : sxfb_pkg::ST_PIX_RD;
      end
      sxfb_pkg::ST_READ: state_d = sxfb_pkg::ST_DONE;
      sxfb_pkg::ST_CLEAR: begin
        if (clr_last) state_d = sxfb_pkg::ST_DONE;
      end
      sxfb_pkg::ST_DONE: begin
        if (slot_free) state_d = sxfb_pkg::ST_IDLE;
      end
      default: state_d = sxfb_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: handshake, memory port and wrap unit operands.
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pix_addr;
    mem_wdata  = rdata_q ^ pix_mask;
    mem_re     = 1'b0;
    mem_raddr  = pix_addr;
    unit_a     = x_q + PosW'(1);
    unit_b     = WidthLim;
    case (state_q)
      sxfb_pkg::ST_IDLE: in_ready_o = 1'b1;
      sxfb_pkg::ST_INIT, sxfb_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'h00;
      end
      sxfb_pkg::ST_XMOD: unit_a = x_q;
      sxfb_pkg::ST_YMOD: begin
        unit_a = y_q;
        unit_b = HeightLim;
      end
      sxfb_pkg::ST_PIX_RD: mem_re = 1'b1;
      sxfb_pkg::ST_PIX_WR: mem_we = 1'b1;
      sxfb_pkg::ST_READ: begin
        mem_re    = read_ok_q;
        mem_raddr = AddrW'(addr_q);
      end
      default: ;
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sxfb_pkg::ST_INIT;
      clr_q       <= '0;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == sxfb_pkg::ST_INIT || state_q == sxfb_pkg::ST_CLEAR) begin
        clr_q <= clr_last ? '0 : clr_q + AddrW'(1);
      end
      if (in_fire) begin
        case (sxfb_pkg::action_e'(action_i))
          sxfb_pkg::ACT_DRAW, sxfb_pkg::ACT_CLEAR: dirty_q <= 1'b1;
          sxfb_pkg::ACT_PRESENT:                   dirty_q <= 1'b0;
          default: ;
        endcase
      end
      if (state_q == sxfb_pkg::ST_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      sxfb_pkg::ST_IDLE: begin
        if (in_fire) begin
          action_q  <= sxfb_pkg::action_e'(action_i);
          x_q       <= x_pos_i;
          y_q       <= y_pos_i;
          spr_q     <= sprite_byte_i;
          addr_q    <= read_address_i;
          read_ok_q <= (32'(read_address_i) < StoreBytes);
          was_q     <= dirty_q;
          hit_q     <= 1'b0;
          cnt_q     <= 3'd0;
        end
      end
      sxfb_pkg::ST_XMOD: x_q <= unit_res;
      sxfb_pkg::ST_YMOD: begin
        y_q <= unit_res;
        if (!unit_ge) row_q <= AddrW'(32'(y_q) * RowBytes);
      end
      sxfb_pkg::ST_PIX_WR: begin
        if ((rdata_q & pix_mask) != 8'h00) hit_q <= 1'b1;
        x_q   <= unit_res;
        cnt_q <= cnt_q + 3'd1;
      end
      default: ;
    endcase
  end

  // Result register, loaded once the output slot is free.
  always_ff @(posedge clk_i) begin
    if (state_q == sxfb_pkg::ST_DONE && slot_free) begin
      coll_q   <= (action_q == sxfb_pkg::ACT_DRAW) && hit_q;
      rbyte_q  <= (action_q == sxfb_pkg::ACT_READ && read_ok_q) ? rdata_q : 8'h00;
      wasmod_q <= (action_q == sxfb_pkg::ACT_PRESENT) && was_q;
    end
  end

  // Pixel store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign collision_o    = coll_q;
  assign read_byte_o    = rbyte_q;
  assign was_modified_o = wasmod_q;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the sprite XOR framebuffer with a shadow pixel store.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod     = 10;
  localparam int ScreenW       = sxfb_pkg::ScreenWidthDefault;
  localparam int ScreenH       = sxfb_pkg::ScreenHeightDefault;
  localparam int PixPerByte    = sxfb_pkg::PixPerByte;
  localparam int RowBytes      = (ScreenW + PixPerByte - 1) / PixPerByte;
  localparam int StoreBytes    = RowBytes * ScreenH;
  localparam int RandomItems   = 1430;
  localparam int QuietTail     = 150;
  localparam int HoldOffAt     = 300;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles   = 300;
  localparam int CycleLimit    = 1500000;
  localparam int DirRows       = 25;

  // One input transaction.
  typedef struct packed {
    sxfb_pkg::action_e act;
    logic [7:0]        x;
    logic [7:0]        y;
    logic [7:0]        spr;
    logic [7:0]        addr;
  } fb_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic       coll;
    logic [7:0] rd;
    logic       was;
  } fb_result_t;

  // Directed row: the command, and a typed-in result where has_fixed is set.
  typedef struct packed {
    sxfb_pkg::action_e act;
    logic [7:0]        x;
    logic [7:0]        y;
    logic [7:0]        spr;
    logic [7:0]        addr;
    logic              has_fixed;
    logic              coll;
    logic [7:0]        rd;
    logic              was;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] action = sxfb_pkg::ACT_DRAW;
  logic [7:0] x_pos = 8'h00;
  logic [7:0] y_pos = 8'h00;
  logic [7:0] sprite_byte = 8'h00;
  logic [7:0] read_address = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       collision;
  logic [7:0] read_byte;
  logic       was_modified;

  // Shadow copy of the pixel store and the modified flag.
  logic [7:0] shadow_pix [StoreBytes];
  logic       shadow_dirty;

  fb_result_t pending_results [$];
  fb_result_t want;
  int         mismatches = 0;
  int         results_seen = 0;
  int         cycles = 0;
  int         gap_pct = 0;
  bit         hold_req = 1'b0;

  dir_row_t dir_rows [DirRows] = '{
    '{sxfb_pkg::ACT_PRESENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_DRAW,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_PRESENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1},
    '{sxfb_pkg::ACT_PRESENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_DRAW,    8'h00, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'hFF, 1'b0},
    '{sxfb_pkg::ACT_DRAW,    8'h00, 8'h00, 8'h80, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h7F, 1'b0},
    '{sxfb_pkg::ACT_DRAW,    8'd60, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'h07, 1'b0, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'h08, 1'b0, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_DRAW,    8'hFF, 8'hFF, 8'hA5, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_DRAW,    8'd64, 8'd32, 8'h01, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_PRESENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_PRESENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_CLEAR,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_PRESENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_DRAW,    8'h07, 8'h1F, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{sxfb_pkg::ACT_READ,    8'h00, 8'h00, 8'h00, 8'hF8, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  sprite_xor_framebuffer_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .x_pos_i        (x_pos),
    .y_pos_i        (y_pos),
    .sprite_byte_i  (sprite_byte),
    .read_address_i (read_address),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .collision_o    (collision),
    .read_byte_o    (read_byte),
    .was_modified_o (was_modified)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Apply one transaction to the shadow store and return its result.
  function automatic fb_result_t fb_shadow_apply(input fb_cmd_t c);
    fb_result_t r;
    int         row_base;
    int         xw;
    int         px;
    int         idx;
    logic [7:0] mask;
    r = '0;
    case (c.act)
      sxfb_pkg::ACT_DRAW: begin
        row_base = (int'(c.y) % ScreenH) * RowBytes;
        xw = int'(c.x) % ScreenW;
        // Pixels past the right edge wrap to the start of the same row.
        for (int i = 0; i < PixPerByte; i++) begin
          if (c.spr[7 - i]) begin
            px = (xw + i) % ScreenW;
            idx = row_base + px / PixPerByte;
            mask = 8'h80 >> (px % PixPerByte);
            if (idx < StoreBytes) begin
              if ((shadow_pix[idx] & mask) != 8'h00) r.coll = 1'b1;
              shadow_pix[idx] = shadow_pix[idx] ^ mask;
            end
          end
        end
        shadow_dirty = 1'b1;
      end
      sxfb_pkg::ACT_CLEAR: begin
        foreach (shadow_pix[k]) shadow_pix[k] = 8'h00;
        shadow_dirty = 1'b1;
      end
      sxfb_pkg::ACT_READ: begin
        if (int'(c.addr) < StoreBytes) r.rd = shadow_pix[c.addr];
      end
      default: begin
        r.was = shadow_dirty;
        shadow_dirty = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Random transaction, biased so draws pile up near the right edge of the top rows.
  function automatic fb_cmd_t fb_random_cmd();
    fb_cmd_t c;
    int      sel;
    sel = $urandom_range(0, 99);
    c.x = 8'($urandom);
    c.y = 8'($urandom);
    c.spr = 8'($urandom);
    c.addr = 8'($urandom);
    if (sel < 50) begin
      c.act = sxfb_pkg::ACT_DRAW;
      if ($urandom_range(0, 1) == 1) begin
        c.x = 8'($urandom_range(0, 3) * 64 + $urandom_range(56, 63));
        c.y = 8'($urandom_range(0, 7) * 32 + $urandom_range(0, 3));
      end
    end else if (sel < 80) begin
      c.act = sxfb_pkg::ACT_READ;
      if ($urandom_range(0, 1) == 1) begin
        c.addr = 8'($urandom_range(0, 3) * RowBytes + ($urandom_range(0, 1) * 7));
      end
    end else if (sel < 97) begin
      c.act = sxfb_pkg::ACT_PRESENT;
    end else begin
      c.act = sxfb_pkg::ACT_CLEAR;
    end
    return c;
  endfunction

  // Report one mismatch and count it.
  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
             $realtime, results_seen, what, got, exp_val);
    mismatches++;
  endtask

  // Offer one transaction, wait for acceptance, then queue its expected result.
  task automatic offer_cmd(input fb_cmd_t c, input bit has_fixed, input fb_result_t fixed_res);
    fb_result_t predicted;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= c.act;
    x_pos        <= c.x;
    y_pos        <= c.y;
    sprite_byte  <= c.spr;
    read_address <= c.addr;
    do @(posedge clk); while (!in_ready);
    predicted = fb_shadow_apply(c);
    pending_results.push_back(has_fixed ? fixed_res : predicted);
  endtask

  // Reset, once at the start of the run.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("sprite_xor_framebuffer_top verification failed");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off to back up the block.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        out_ready <= 1'b1;
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (collision !== want.coll) report_mismatch("collision", collision, want.coll);
        if (read_byte !== want.rd) report_mismatch("read_byte", read_byte, want.rd);
        if (was_modified !== want.was) begin
          report_mismatch("was_modified", was_modified, want.was);
        end
      end
    end
  end

  // Input side: directed table, then random transactions, then drain and verdict.
  initial begin
    fb_cmd_t    c;
    fb_result_t fixed_res;
    foreach (shadow_pix[k]) shadow_pix[k] = 8'h00;
    shadow_dirty = 1'b0;
    @(posedge rst_n);
    @(posedge clk);

    foreach (dir_rows[i]) begin
      c = '{dir_rows[i].act, dir_rows[i].x, dir_rows[i].y, dir_rows[i].spr, dir_rows[i].addr};
      fixed_res = '{dir_rows[i].coll, dir_rows[i].rd, dir_rows[i].was};
      offer_cmd(c, dir_rows[i].has_fixed, fixed_res);
    end

    for (int n = 0; n < RandomItems; n++) begin
      // New idling pattern every hundred transactions; none near the end.
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 10;
          2: gap_pct = 30;
          default: gap_pct = 60;
        endcase
      end
      if (n >= RandomItems - QuietTail) gap_pct = 0;
      if (n == HoldOffAt) hold_req = 1'b1;
      offer_cmd(fb_random_cmd(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("sprite_xor_framebuffer_top verification clean");
    end else begin
      $display("sprite_xor_framebuffer_top verification failed");
    end
    $finish;
  end

endmodule
